// File: hw/rtl/cholesky_linear_solver_macros.svh
// Assertion macros shared by the solver.
// Each expects a clock named i_clk and an active low reset named i_rst_n in scope.
`ifndef CHOLESKY_LINEAR_SOLVER_MACROS_SVH
`define CHOLESKY_LINEAR_SOLVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("solver assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("solver assertion failed");

`endif

// File: hw/rtl/cls_pkg.sv
package cls_pkg;

    localparam int REQ_BITS   = 2;
    localparam int IDX_BITS   = 4;
    localparam int VAL_BITS   = 32;
    localparam int ORDER_BITS = 5;

    localparam logic [REQ_BITS-1:0]   REQ_LOAD_A = 2'd0;
    localparam logic [REQ_BITS-1:0]   REQ_LOAD_B = 2'd1;
    localparam logic [REQ_BITS-1:0]   REQ_SOLVE  = 2'd2;

    localparam logic [ORDER_BITS-1:0] ORDER_RESET = 5'd16;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } t_alu_op;

    typedef enum logic [1:0] {
        PH_FACT,
        PH_FWD,
        PH_BACK
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOT_START,
        ST_DOT_RA,
        ST_DOT_RB,
        ST_DOT_MUL,
        ST_DOT_ACC,
        ST_BASE_RD,
        ST_BASE_OP,
        ST_BASE_WAIT,
        ST_EMIT_RD,
        ST_EMIT_SHOW
    } t_state;

endpackage

// File: hw/rtl/cls_ifs.sv
interface cls_in_if;
    logic                                valid;
    logic                                ready;
    logic [cls_pkg::REQ_BITS-1:0]        req_type;
    logic [cls_pkg::IDX_BITS-1:0]        row;
    logic [cls_pkg::IDX_BITS-1:0]        col;
    logic signed [cls_pkg::VAL_BITS-1:0] value;

    modport source (output valid, req_type, row, col, value, input ready);
    modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

interface cls_out_if;
    logic                                valid;
    logic                                ready;
    logic [cls_pkg::IDX_BITS-1:0]        index;
    logic signed [cls_pkg::VAL_BITS-1:0] solution;
    logic                                last;
    logic                                not_positive_definite;

    modport source (output valid, index, solution, last, not_positive_definite, input ready);
    modport sink   (input valid, index, solution, last, not_positive_definite, output ready);
endinterface

interface cls_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cls_pkg::ORDER_BITS-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/cls_ram.sv
module cls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/cls_alu.sv
module cls_alu #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  cls_pkg::t_alu_op    i_op,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic                o_done,
    output logic signed [W-1:0] o_res
);

    localparam int QW   = W + F;
    localparam int SB   = (W + F + 1) / 2;
    localparam int NB   = 2 * SB;
    localparam int PW   = 2 * W;
    localparam int MW   = (PW > QW) ? PW : QW;
    localparam int RW   = (W > SB + 2) ? W : SB + 2;
    localparam int CNTW = $clog2(NB + 1);

    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    logic             r_busy, r_fin, r_done, r_neg;
    cls_pkg::t_alu_op r_op;
    logic [CNTW-1:0]  r_cnt;
    logic [NB-1:0]    r_num;
    logic [W-1:0]     r_den;
    logic [RW-1:0]    r_rem;
    logic [QW-1:0]    r_quo;
    logic [PW-1:0]    r_prod;
    logic [W-1:0]     r_res;

    logic [W-1:0]     ma, mb;
    logic [W:0]       div_rem2;
    logic             div_bit;
    logic [SB+3:0]    sq_rem2;
    logic [SB+3:0]    sq_trial;
    logic             sq_bit;
    logic [MW-1:0]    fin_mag, fin_lim, fin_sat;
    logic [PW-1:0]    mul_sh;

    assign ma = i_a[W-1] ? W'(-i_a) : W'(i_a);
    assign mb = i_b[W-1] ? W'(-i_b) : W'(i_b);

    always_comb begin
        div_rem2 = {r_rem[W-1:0], r_num[NB-1]};
        div_bit  = (div_rem2 >= {1'b0, r_den});
        sq_rem2  = {r_rem[SB+1:0], r_num[NB-1:NB-2]};
        sq_trial = (SB+4)'({r_quo[SB-1:0], 2'b01});
        sq_bit   = (sq_rem2 >= sq_trial);
        mul_sh   = r_prod >> F;
        if (r_op == cls_pkg::ALU_MUL) begin
            fin_mag = MW'(mul_sh) + MW'(r_neg && (r_prod[F-1:0] != '0));
        end else begin
            fin_mag = MW'(r_quo);
        end
        fin_lim = r_neg ? MW'(WMIN) : MW'(WMAX);
        fin_sat = (fin_mag > fin_lim) ? fin_lim : fin_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_op  <= i_op;
                r_rem <= '0;
                r_quo <= '0;
                r_num <= NB'(ma) << F;
                r_den <= mb;
                case (i_op)
                    cls_pkg::ALU_MUL: begin
                        r_prod <= PW'(ma) * PW'(mb);
                        r_neg  <= i_a[W-1] ^ i_b[W-1];
                        r_busy <= 1'b1;
                        r_fin  <= 1'b1;
                    end
                    cls_pkg::ALU_DIV: begin
                        r_neg <= i_a[W-1] ^ i_b[W-1];
                        if (mb == '0) begin
                            // Zero divisor saturates by the sign of the dividend, or gives zero for a zero dividend.
                            r_res  <= (i_a == '0) ? '0 : (i_a[W-1] ? WMIN : WMAX);
                            r_done <= 1'b1;
                        end else begin
                            r_cnt  <= CNTW'(NB);
                            r_busy <= 1'b1;
                            r_fin  <= 1'b0;
                        end
                    end
                    default: begin
                        r_neg  <= 1'b0;
                        r_cnt  <= CNTW'(SB);
                        r_busy <= 1'b1;
                        r_fin  <= 1'b0;
                    end
                endcase
            end else if (r_busy && !r_fin) begin
                if (r_op == cls_pkg::ALU_DIV) begin
                    r_rem <= div_bit ? RW'(div_rem2 - {1'b0, r_den}) : RW'(div_rem2);
                    r_quo <= {r_quo[QW-2:0], div_bit};
                    r_num <= r_num << 1;
                end else begin
                    r_rem <= sq_bit ? RW'(sq_rem2 - sq_trial) : RW'(sq_rem2);
                    r_quo <= {r_quo[QW-2:0], sq_bit};
                    r_num <= r_num << 2;
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_fin <= 1'b1;
                end
            end else if (r_busy) begin
                r_res  <= r_neg ? W'(-fin_sat) : W'(fin_sat);
                r_done <= 1'b1;
                r_busy <= 1'b0;
                r_fin  <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// File: hw/rtl/cholesky_linear_solver.sv
// A matrix or right-hand-side word can be loaded every cycle while the block is idle.
// A solve performs about n^3/6 + n^2 multiply-adds, n(n+3)/2 divisions and n square roots,
// all on the shared arithmetic unit, and then emits n words. No new word is taken meanwhile.
// Reset (synchronous, active low) returns the sequencer to idle and the order to 16;
// the matrix, factor and vector memories are not cleared.
`include "cholesky_linear_solver_macros.svh"

module cholesky_linear_solver #(
    parameter int MAX_ORDER = 16,
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cls_in_if.sink       i_in,
    cls_cfg_if.sink      i_cfg,
    cls_out_if.source    o_out
);

    localparam int W  = WORD_BITS;
    localparam int IW = $clog2(MAX_ORDER);
    localparam int CW = $clog2(MAX_ORDER + 1);

    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [63:0] WMAX64 = 64'($signed({1'b0, {(W-1){1'b1}}}));
    localparam logic signed [63:0] WMIN64 = 64'($signed({1'b1, {(W-1){1'b0}}}));

    // Saturating add and subtract on the working word.
    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? WMIN : WMAX;
        end
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? WMIN : WMAX;
        end
        return s[W-1:0];
    endfunction

    // Sequencer and loop state.
    cls_pkg::t_state r_state, n_state;
    cls_pkg::t_phase r_phase;
    logic [cls_pkg::ORDER_BITS-1:0] r_order;
    logic [CW-1:0]           r_n, r_m;
    logic [IW-1:0]           r_i, r_j, r_e;
    logic                    r_fail;
    logic signed [W-1:0]     r_sum, r_opa;

    // Memory ports.
    logic                    a_we, s_we, v_we;
    logic [2*IW-1:0]         a_waddr, a_raddr, s_waddr, s_raddr;
    logic [IW:0]             v_waddr, v_raddr;
    logic signed [W-1:0]     a_wdata, s_wdata, v_wdata;
    logic signed [W-1:0]     a_rdata, s_rdata, v_rdata;

    // Shared arithmetic unit.
    logic                    alu_start, alu_done;
    cls_pkg::t_alu_op        alu_op;
    logic signed [W-1:0]     alu_a, alu_b, alu_res;

    logic                    in_fire, out_fire;
    logic signed [63:0]      in_v64, out_v64;
    logic signed [W-1:0]     load_val, base_val, diff;
    logic [CW-1:0]           dot_limit, dot_start, n_clamped;
    logic [2*IW-1:0]         addr_a, addr_b;
    logic                    diag, bad_pivot, row_ok, col_ok;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;

    // The incoming word is sign extended, then clamped to the working range.
    always_comb begin
        in_v64 = 64'(i_in.value);
        if (in_v64 > WMAX64) begin
            load_val = WMAX;
        end else if (in_v64 < WMIN64) begin
            load_val = WMIN;
        end else begin
            load_val = W'(in_v64);
        end
    end

    assign row_ok = (int'(i_in.row) < MAX_ORDER);
    assign col_ok = (int'(i_in.col) < MAX_ORDER);

    always_comb begin
        if (r_order == '0) begin
            n_clamped = CW'(1);
        end else if (int'(r_order) > MAX_ORDER) begin
            n_clamped = CW'(MAX_ORDER);
        end else begin
            n_clamped = CW'(r_order);
        end
    end

    // Dot product bounds: forward sweeps run k from 0 up to the row, the back
    // substitution runs from the row plus one up to the order.
    assign dot_limit = (r_phase == cls_pkg::PH_BACK) ? r_n : CW'(r_i);
    assign dot_start = (r_phase == cls_pkg::PH_BACK) ? CW'(r_i) + 1'b1 : '0;
    assign addr_a    = (r_phase == cls_pkg::PH_BACK) ? {r_i, r_m[IW-1:0]}
                                                     : {r_m[IW-1:0], r_i};
    assign addr_b    = {r_m[IW-1:0], r_j};
    assign diag      = (r_phase == cls_pkg::PH_FACT) && (r_i == r_j);

    assign base_val  = (r_phase == cls_pkg::PH_FACT) ? a_rdata : v_rdata;
    assign diff      = sat_sub(base_val, r_sum);
    assign bad_pivot = diag && (diff[W-1] || (diff == '0));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cls_pkg::ST_IDLE: begin
                if (in_fire && i_in.req_type == cls_pkg::REQ_SOLVE) begin
                    n_state = cls_pkg::ST_DOT_START;
                end
            end
            cls_pkg::ST_DOT_START: begin
                n_state = (dot_start == dot_limit) ? cls_pkg::ST_BASE_RD : cls_pkg::ST_DOT_RA;
            end
            cls_pkg::ST_DOT_RA:  n_state = cls_pkg::ST_DOT_RB;
            cls_pkg::ST_DOT_RB:  n_state = cls_pkg::ST_DOT_MUL;
            cls_pkg::ST_DOT_MUL: n_state = cls_pkg::ST_DOT_ACC;
            cls_pkg::ST_DOT_ACC: begin
                if (alu_done) begin
                    n_state = (r_m + 1'b1 == dot_limit) ? cls_pkg::ST_BASE_RD
                                                        : cls_pkg::ST_DOT_RA;
                end
            end
            cls_pkg::ST_BASE_RD: n_state = cls_pkg::ST_BASE_OP;
            cls_pkg::ST_BASE_OP: begin
                n_state = bad_pivot ? cls_pkg::ST_EMIT_RD : cls_pkg::ST_BASE_WAIT;
            end
            cls_pkg::ST_BASE_WAIT: begin
                if (alu_done) begin
                    n_state = (r_phase == cls_pkg::PH_BACK && r_i == '0) ? cls_pkg::ST_EMIT_RD
                                                                         : cls_pkg::ST_DOT_START;
                end
            end
            cls_pkg::ST_EMIT_RD: n_state = cls_pkg::ST_EMIT_SHOW;
            cls_pkg::ST_EMIT_SHOW: begin
                if (out_fire) begin
                    n_state = (CW'(r_e) + 1'b1 == r_n) ? cls_pkg::ST_IDLE : cls_pkg::ST_EMIT_RD;
                end
            end
            default: n_state = cls_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory addresses, arithmetic requests, handshakes.
    always_comb begin
        alu_start = 1'b0;
        alu_op    = cls_pkg::ALU_MUL;
        alu_a     = r_opa;
        alu_b     = (r_phase == cls_pkg::PH_FACT) ? s_rdata : v_rdata;
        s_raddr   = addr_a;
        v_raddr   = {1'b1, r_m[IW-1:0]};
        case (r_state)
            cls_pkg::ST_DOT_RB: begin
                s_raddr = addr_b;
            end
            cls_pkg::ST_DOT_MUL: begin
                alu_start = 1'b1;
            end
            cls_pkg::ST_BASE_RD: begin
                s_raddr = {r_i, r_i};
                v_raddr = {(r_phase != cls_pkg::PH_FWD), r_i};
            end
            cls_pkg::ST_BASE_OP: begin
                alu_start = !bad_pivot;
                alu_op    = diag ? cls_pkg::ALU_SQRT : cls_pkg::ALU_DIV;
                alu_a     = diff;
                alu_b     = s_rdata;
            end
            cls_pkg::ST_EMIT_RD, cls_pkg::ST_EMIT_SHOW: begin
                v_raddr = {1'b1, r_e};
            end
            default: begin
                s_raddr = addr_a;
            end
        endcase

        a_raddr = {r_i, r_j};
        a_we    = in_fire && i_in.req_type == cls_pkg::REQ_LOAD_A && row_ok && col_ok;
        a_waddr = {IW'(i_in.row), IW'(i_in.col)};
        a_wdata = load_val;

        s_we    = (r_state == cls_pkg::ST_BASE_WAIT) && alu_done &&
                  (r_phase == cls_pkg::PH_FACT);
        s_waddr = {r_i, r_j};
        s_wdata = alu_res;

        // The vector memory holds b in its lower half and z, later x, in its upper half.
        if (r_state == cls_pkg::ST_IDLE) begin
            v_we    = in_fire && i_in.req_type == cls_pkg::REQ_LOAD_B && row_ok;
            v_waddr = {1'b0, IW'(i_in.row)};
            v_wdata = load_val;
        end else begin
            v_we    = (r_state == cls_pkg::ST_BASE_WAIT) && alu_done &&
                      (r_phase != cls_pkg::PH_FACT);
            v_waddr = {1'b1, r_i};
            v_wdata = alu_res;
        end

        i_in.ready  = (r_state == cls_pkg::ST_IDLE);
        i_cfg.ready = 1'b1;

        out_v64                     = 64'(v_rdata);
        o_out.valid                 = (r_state == cls_pkg::ST_EMIT_SHOW);
        o_out.index                 = cls_pkg::IDX_BITS'(r_e);
        o_out.solution              = r_fail ? '0 : out_v64[cls_pkg::VAL_BITS-1:0];
        o_out.last                  = (CW'(r_e) + 1'b1 == r_n);
        o_out.not_positive_definite = r_fail;
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cls_pkg::ST_IDLE;
            r_order <= cls_pkg::ORDER_RESET;
            r_phase <= cls_pkg::PH_FACT;
            r_fail  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_order <= i_cfg.data;
            end
            case (r_state)
                cls_pkg::ST_IDLE: begin
                    if (in_fire && i_in.req_type == cls_pkg::REQ_SOLVE) begin
                        r_n     <= n_clamped;
                        r_phase <= cls_pkg::PH_FACT;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_fail  <= 1'b0;
                    end
                end
                cls_pkg::ST_DOT_START: begin
                    r_m   <= dot_start;
                    r_sum <= '0;
                end
                cls_pkg::ST_DOT_RB: begin
                    r_opa <= s_rdata;
                end
                cls_pkg::ST_DOT_ACC: begin
                    if (alu_done) begin
                        r_sum <= sat_add(r_sum, alu_res);
                        r_m   <= r_m + 1'b1;
                    end
                end
                cls_pkg::ST_BASE_OP: begin
                    if (bad_pivot) begin
                        r_fail <= 1'b1;
                        r_e    <= '0;
                    end
                end
                cls_pkg::ST_BASE_WAIT: begin
                    if (alu_done) begin
                        case (r_phase)
                            cls_pkg::PH_FACT: begin
                                if (CW'(r_j) + 1'b1 < r_n) begin
                                    r_j <= r_j + 1'b1;
                                end else if (CW'(r_i) + 1'b1 < r_n) begin
                                    r_i <= r_i + 1'b1;
                                    r_j <= r_i + 1'b1;
                                end else begin
                                    r_phase <= cls_pkg::PH_FWD;
                                    r_i     <= '0;
                                end
                            end
                            cls_pkg::PH_FWD: begin
                                if (CW'(r_i) + 1'b1 < r_n) begin
                                    r_i <= r_i + 1'b1;
                                end else begin
                                    r_phase <= cls_pkg::PH_BACK;
                                    r_i     <= IW'(r_n - 1'b1);
                                end
                            end
                            default: begin
                                if (r_i == '0) begin
                                    r_e <= '0;
                                end else begin
                                    r_i <= r_i - 1'b1;
                                end
                            end
                        endcase
                    end
                end
                cls_pkg::ST_EMIT_SHOW: begin
                    if (out_fire) begin
                        r_e <= r_e + 1'b1;
                    end
                end
                default: begin
                    r_fail <= r_fail;
                end
            endcase
        end
    end

    cls_ram #(.WIDTH(W), .DEPTH(1 << (2 * IW))) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    cls_ram #(.WIDTH(W), .DEPTH(1 << (2 * IW))) u_s_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    cls_ram #(.WIDTH(W), .DEPTH(2 << IW)) u_v_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    cls_alu #(.W(W), .F(FRAC_BITS)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (alu_start),
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    // The block never takes a word while it is presenting a result.
    `CLS_ASSERT_SAME(a_no_overlap, i_in.ready, !o_out.valid)
    // After the final result is taken the block is ready again.
    `CLS_ASSERT_NEXT(a_ready_after_last, out_fire && o_out.last, i_in.ready)
    // A failed factoring reports zeros.
    `CLS_ASSERT_SAME(a_fail_zero, o_out.valid && o_out.not_positive_definite,
                     o_out.solution == '0)

endmodule
